/* hw/rtl/mfb_pkg.sv */
// Shared types and constants for the monochrome frame buffer pixel engine.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mfb_pkg;

  localparam int ROW_BYTES_DEF = 32;
  localparam int ROWS_DEF      = 128;

  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;
  localparam int BYTE_W      = 8;

  // Wide enough for row * ROW_BYTES + column at the largest parameter values.
  localparam int ADDR_CALC_W = 16;

  typedef enum logic [1:0] {
    FUNC_PLOT  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_SHIFT = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic update;
    logic update2;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic  clear_last;
    func_t in_func;
    func_t func;
    logic  next_ok;
    logic  out_free;
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/mfb_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// Stand-alone; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module mfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                                       clk,
  input  wire logic                                       wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                           wr_data,
  input  wire logic                                       rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/mfb_ctrl.sv */
// Controller state machine of the frame buffer pixel engine.
// Depends on mfb_pkg for the command and status structures.
`timescale 1ns / 1ps
`default_nettype none

module mfb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire mfb_pkg::sts_t sts,
  output mfb_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_CLEAR   = 4'b0001,
    S_IDLE    = 4'b0010,
    S_UPDATE  = 4'b0100,
    S_UPDATE2 = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          if (sts.in_func != mfb_pkg::FUNC_WRITE) begin
            state_next = S_UPDATE;
          end
        end
      end
      S_UPDATE: begin
        if (sts.func == mfb_pkg::FUNC_READ) begin
          if (sts.out_free) begin
            cmd.load_out = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.update = 1'b1;
          if (sts.func == mfb_pkg::FUNC_SHIFT && sts.next_ok) begin
            state_next = S_UPDATE2;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_UPDATE2: begin
        cmd.update2 = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/mfb_datapath.sv */
// Datapath of the frame buffer pixel engine: item register, address and merge
// logic, frame store and output register. Depends on mfb_pkg and mfb_ram.
`timescale 1ns / 1ps
`default_nettype none

module mfb_datapath #(
  parameter int ROW_BYTES = mfb_pkg::ROW_BYTES_DEF,
  parameter int ROWS      = mfb_pkg::ROWS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire mfb_pkg::cmd_t                      cmd,
  output mfb_pkg::sts_t                           sts,
  input  wire logic [mfb_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  wire logic [mfb_pkg::IN_TUSER_W-1:0]     s_tuser,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic      [mfb_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  localparam int DEPTH = ROW_BYTES * ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BW    = mfb_pkg::BYTE_W;
  localparam int CW    = mfb_pkg::ADDR_CALC_W;

  logic [7:0]           in_x;
  logic [6:0]           in_y;
  logic                 in_on;
  logic [BW-1:0]        in_val;
  logic [2:0]           in_sh;
  mfb_pkg::func_t       in_func;
  logic [6:0]           col_w;
  logic                 ok_live;
  logic                 next_ok_live;
  logic [CW-1:0]        addr_full;
  logic [AW-1:0]        addr_live;

  mfb_pkg::func_t       func_q;
  logic [2:0]           x_lo;
  logic                 on_q;
  logic [BW-1:0]        val_q;
  logic [2:0]           sh_q;
  logic [AW-1:0]        addr_q;
  logic                 ok_q;
  logic                 next_ok_q;
  logic [AW-1:0]        addr_next;
  logic [AW-1:0]        clr_cnt;

  logic [BW-1:0]        rd_q;
  logic [BW-1:0]        bit_mask;
  logic [BW-1:0]        plot_byte;
  logic [BW-1:0]        shift_byte;
  logic [2*BW-1:0]      spill_wide;
  logic [BW-1:0]        next_byte;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [BW-1:0]        wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;

  // Input transfer fields, lowest bits first.
  assign in_x    = s_tdata[7:0];
  assign in_y    = s_tdata[14:8];
  assign in_on   = s_tdata[15];
  assign in_val  = s_tdata[23:16];
  assign in_sh   = s_tdata[26:24];
  assign in_func = mfb_pkg::func_t'(s_tuser);

  assign col_w        = {2'b00, in_x[7:3]};
  assign ok_live      = (col_w < 7'(ROW_BYTES)) && ({2'b00, in_y} < 9'(ROWS));
  assign next_ok_live = ok_live && (in_sh != 3'd0) && ((col_w + 7'd1) < 7'(ROW_BYTES));
  assign addr_full    = CW'(in_y) * CW'(ROW_BYTES) + CW'(in_x[7:3]);
  assign addr_live    = addr_full[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_q    <= in_func;
      x_lo      <= in_x[2:0];
      on_q      <= in_on;
      val_q     <= in_val;
      sh_q      <= in_sh;
      addr_q    <= addr_live;
      ok_q      <= ok_live;
      next_ok_q <= next_ok_live;
    end
  end

  assign addr_next = addr_q + AW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  assign bit_mask   = 8'h80 >> x_lo;
  assign plot_byte  = on_q ? (rd_q | bit_mask) : (rd_q & ~bit_mask);
  assign shift_byte = (rd_q & ~(8'hff >> sh_q)) | (val_q >> sh_q);
  assign spill_wide = {val_q, 8'h00} >> sh_q;
  assign next_byte  = (rd_q & (8'hff >> sh_q)) | spill_wide[BW-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_q;
    wr_data = '0;
    rd_en   = 1'b0;
    rd_addr = addr_live;
    priority if (cmd.clear) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
    end else if (cmd.accept) begin
      rd_en = ok_live;
      if (in_func == mfb_pkg::FUNC_WRITE) begin
        wr_en   = ok_live;
        wr_addr = addr_live;
        wr_data = in_val;
      end
    end else if (cmd.update) begin
      wr_en   = ok_q;
      wr_data = (func_q == mfb_pkg::FUNC_PLOT) ? plot_byte : shift_byte;
      rd_en   = next_ok_q;
      rd_addr = addr_next;
    end else if (cmd.update2) begin
      wr_en   = 1'b1;
      wr_addr = addr_next;
      wr_data = next_byte;
    end else begin
      wr_en = 1'b0;
    end
  end

  mfb_ram #(
    .WIDTH (BW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= ok_q ? rd_q : '0;
    end
  end

  assign sts.clear_last = (clr_cnt == AW'(DEPTH - 1));
  assign sts.in_func    = in_func;
  assign sts.func       = func_q;
  assign sts.next_ok    = next_ok_q;
  assign sts.out_free   = !m_tvalid || m_tready;

endmodule

`default_nettype wire

/* hw/rtl/mono_frame_buffer_pixel_engine.sv */
// Top level of the monochrome frame buffer pixel engine.
// Depends on mfb_pkg, mfb_ctrl and mfb_datapath.
//
// One bit per pixel, ROWS rows of ROW_BYTES bytes, bit 7 the leftmost pixel.
// After reset the block clears all ROW_BYTES * ROWS bytes of the frame store
// one byte per cycle and takes no transfer until that is done. Items are then
// handled one at a time, with the frame store's single write port and
// registered read port setting the pace: an aligned byte write is written as
// it is taken, a pixel plot reads its byte and then writes it back, a shifted
// byte write does the same and, when it spills into the next byte of the row,
// also writes that byte, and a read waits until any previous result is taken.
// Out-of-range writes change nothing and out-of-range reads return zero.
`timescale 1ns / 1ps
`default_nettype none

module mono_frame_buffer_pixel_engine #(
  parameter int ROW_BYTES = mfb_pkg::ROW_BYTES_DEF,
  parameter int ROWS      = mfb_pkg::ROWS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // pixel_x[7:0], pixel_y[14:8], pixel_on[15], byte_value[23:16],
  // bit_shift[26:24], zeros above.
  input  wire logic [mfb_pkg::IN_TDATA_W-1:0]   s_tdata,
  // func[1:0].
  input  wire logic [mfb_pkg::IN_TUSER_W-1:0]   s_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // read_byte[7:0].
  output logic      [mfb_pkg::OUT_TDATA_W-1:0]  m_tdata
);

  mfb_pkg::cmd_t cmd;
  mfb_pkg::sts_t sts;

  mfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mfb_datapath #(
    .ROW_BYTES (ROW_BYTES),
    .ROWS      (ROWS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !cmd.clear)
    else $error("Input ready raised during the clearing pass.");

  a_load_into_free_output: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_tvalid || m_tready))
    else $error("Result loaded while the previous one was still waiting.");

  a_spill_follows_update: assert property (@(posedge clk) disable iff (rst)
    cmd.update2 |-> $past(cmd.update))
    else $error("Spill write without a preceding first-byte update.");

  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.load_out))
    else $error("Output valid raised without a result being loaded.");

endmodule

`default_nettype wire

/* verif/mono_frame_buffer_pixel_engine_tb.sv */
// Self-checking testbench for the monochrome frame buffer pixel engine.
// It drives plots, byte writes, shifted writes and reads, checks read-back bytes
// against a shadow frame or fixed bytes, and depends only on mfb_pkg and the top level.
`timescale 1ns / 1ps

module mono_frame_buffer_pixel_engine_tb;
  import mfb_pkg::*;

  localparam int ROW_BYTES    = ROW_BYTES_DEF;
  localparam int ROWS         = ROWS_DEF;
  localparam int NUM_DIRECTED = 22;
  localparam int NUM_RANDOM   = 1950;
  localparam int IDLE_LIMIT   = 20000;

  typedef struct packed {
    func_t      func;
    logic [7:0] pixel_x;
    logic [6:0] pixel_y;
    logic       pixel_on;
    logic [7:0] byte_value;
    logic [2:0] bit_shift;
  } pix_op_t;

  typedef struct packed {
    pix_op_t    op;
    logic       fixed;
    logic [7:0] fixed_byte;
  } directed_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  logic [7:0] shadow_frame [ROW_BYTES*ROWS];
  logic [7:0] expected_read_bytes [$];
  int         mismatches = 0;
  int         idle_cycles = 0;
  int         stall_left = 0;
  bit         sender_quiet = 0;
  bit         receiver_quiet = 0;

  // Reads, plot and write rows first, then shifted writes with no shift, a full
  // shift, a spill into the next byte and a spill past the row end, and a last plot.
  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{'{FUNC_READ,  8'd0,   7'd0,   1'b0, 8'h00, 3'd0}, 1'b1, 8'h00},
    '{'{FUNC_READ,  8'd255, 7'd127, 1'b1, 8'hff, 3'd7}, 1'b1, 8'h00},
    '{'{FUNC_WRITE, 8'd0,   7'd0,   1'b0, 8'hff, 3'd0}, 1'b0, 8'h00},
    '{'{FUNC_READ,  8'd0,   7'd0,   1'b0, 8'h00, 3'd0}, 1'b1, 8'hff},
    '{'{FUNC_PLOT,  8'd3,   7'd0,   1'b0, 8'h00, 3'd0}, 1'b0, 8'h00},
    '{'{FUNC_READ,  8'd7,   7'd0,   1'b0, 8'h00, 3'd0}, 1'b0, 8'h00},
    '{'{FUNC_PLOT,  8'd255, 7'd127, 1'b1, 8'h00, 3'd0}, 1'b0, 8'h00},
    '{'{FUNC_READ,  8'd248, 7'd127, 1'b0, 8'h00, 3'd0}, 1'b1, 8'h01},
    '{'{FUNC_WRITE, 8'd16,  7'd1,   1'b0, 8'hff, 3'd0}, 1'b0, 8'h00},
    '{'{FUNC_SHIFT, 8'd8,   7'd1,   1'b0, 8'ha5, 3'd0}, 1'b0, 8'h00},
    '{'{FUNC_READ,  8'd8,   7'd1,   1'b0, 8'h00, 3'd0}, 1'b1, 8'ha5},
    '{'{FUNC_READ,  8'd16,  7'd1,   1'b0, 8'h00, 3'd0}, 1'b1, 8'hff},
    '{'{FUNC_SHIFT, 8'd8,   7'd1,   1'b0, 8'hff, 3'd7}, 1'b0, 8'h00},
    '{'{FUNC_READ,  8'd8,   7'd1,   1'b0, 8'h00, 3'd0}, 1'b0, 8'h00},
    '{'{FUNC_SHIFT, 8'd15,  7'd1,   1'b0, 8'h81, 3'd3}, 1'b0, 8'h00},
    '{'{FUNC_READ,  8'd8,   7'd1,   1'b0, 8'h00, 3'd0}, 1'b0, 8'h00},
    '{'{FUNC_READ,  8'd23,  7'd1,   1'b0, 8'h00, 3'd0}, 1'b0, 8'h00},
    '{'{FUNC_SHIFT, 8'd248, 7'd2,   1'b0, 8'hff, 3'd4}, 1'b0, 8'h00},
    '{'{FUNC_READ,  8'd248, 7'd2,   1'b0, 8'h00, 3'd0}, 1'b1, 8'h0f},
    '{'{FUNC_READ,  8'd0,   7'd3,   1'b0, 8'h00, 3'd0}, 1'b1, 8'h00},
    '{'{FUNC_PLOT,  8'd7,   7'd5,   1'b1, 8'h00, 3'd0}, 1'b0, 8'h00},
    '{'{FUNC_READ,  8'd0,   7'd5,   1'b0, 8'h00, 3'd0}, 1'b1, 8'h01}
  };

  mono_frame_buffer_pixel_engine u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic apply_pixel_op(input pix_op_t op, output bit has_read,
                                output logic [7:0] read_val);
    int unsigned col;
    int unsigned addr;
    logic [7:0]  keep_mask;
    logic [7:0]  pix_bit;
    bit          in_range;
    col       = 32'(op.pixel_x[7:3]);
    in_range  = (col < ROW_BYTES) && (op.pixel_y < ROWS);
    addr      = op.pixel_y * ROW_BYTES + col;
    has_read  = 1'b0;
    read_val  = 8'h00;
    pix_bit   = 8'h80 >> op.pixel_x[2:0];
    keep_mask = 8'hff >> op.bit_shift;
    case (op.func)
      FUNC_PLOT: begin
        if (in_range) begin
          if (op.pixel_on) shadow_frame[addr] = shadow_frame[addr] | pix_bit;
          else shadow_frame[addr] = shadow_frame[addr] & ~pix_bit;
        end
      end
      FUNC_WRITE: begin
        if (in_range) shadow_frame[addr] = op.byte_value;
      end
      FUNC_SHIFT: begin
        if (in_range) begin
          shadow_frame[addr] = (shadow_frame[addr] & ~keep_mask) |
                               (op.byte_value >> op.bit_shift);
          if (op.bit_shift != 3'd0 && col + 1 < ROW_BYTES) begin
            shadow_frame[addr+1] = (shadow_frame[addr+1] & keep_mask) |
                                   (op.byte_value << (8 - op.bit_shift));
          end
        end
      end
      default: begin
        has_read = 1'b1;
        read_val = in_range ? shadow_frame[addr] : 8'h00;
      end
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic drive_pixel_op(input pix_op_t op, input logic fixed,
                                input logic [7:0] fixed_byte);
    int         gap;
    bit         has_read;
    logic [7:0] read_val;
    if ($urandom_range(0, 79) == 0) sender_quiet = !sender_quiet;
    gap = sender_quiet ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, op.bit_shift, op.byte_value, op.pixel_on, op.pixel_y, op.pixel_x};
    s_tuser  <= op.func;
    do @(posedge clk); while (!s_tready);
    apply_pixel_op(op, has_read, read_val);
    if (has_read) expected_read_bytes.push_back(fixed ? fixed_byte : read_val);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_read_bytes.size() == 0) begin
        $display("%0t: unexpected read byte, expected none, actual 0x%02h", $time, m_tdata);
        mismatches++;
      end else begin
        if (m_tdata !== expected_read_bytes[0]) begin
          $display("%0t: read byte mismatch, expected 0x%02h, actual 0x%02h",
                   $time, expected_read_bytes[0], m_tdata);
          mismatches++;
        end
        void'(expected_read_bytes.pop_front());
      end
      if ($urandom_range(0, 39) == 0) receiver_quiet = !receiver_quiet;
      stall_left <= receiver_quiet ? 0 : $urandom_range(0, 6);
    end
  end

  always @(negedge clk) begin
    if (rst || stall_left > 0) begin
      m_tready <= 1'b0;
      if (!rst) stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    pix_op_t op;
    int      pick;
    for (int i = 0; i < ROW_BYTES*ROWS; i++) shadow_frame[i] = 8'h00;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      drive_pixel_op(directed_rows[i].op, directed_rows[i].fixed, directed_rows[i].fixed_byte);
    end

    // Most items stay in a few rows so that reads return bytes built up by writes.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) op.func = FUNC_PLOT;
      else if (pick < 45) op.func = FUNC_WRITE;
      else if (pick < 75) op.func = FUNC_SHIFT;
      else op.func = FUNC_READ;
      op.pixel_x    = 8'($urandom_range(0, 255));
      op.pixel_y    = 7'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 3)
                                                    : $urandom_range(0, 127));
      op.pixel_on   = 1'($urandom_range(0, 1));
      op.byte_value = 8'($urandom_range(0, 255));
      op.bit_shift  = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 9) == 0) op.pixel_x[7:3] = 5'd31;
      drive_pixel_op(op, 1'b0, 8'h00);
    end
    s_tvalid <= 1'b0;

    while (expected_read_bytes.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/mfb_pkg.sv
hw/rtl/mfb_ram.sv
hw/rtl/mfb_ctrl.sv
hw/rtl/mfb_datapath.sv
hw/rtl/mono_frame_buffer_pixel_engine.sv
verif/mono_frame_buffer_pixel_engine_tb.sv
